>>> rtl/pccm_pkg.sv
// pccm_pkg: shared types and constants for the per-channel charge mean block
// no dependencies
`timescale 1ns / 1ps

package pccm_pkg;

  localparam int CHANNELS  = 9728;
  localparam int ADDR_W    = $clog2(CHANNELS);
  localparam int CHAN_W    = 14;
  localparam int CHG_W     = 12;
  localparam int SUM_W     = 32;
  localparam int MEAN_W    = 16;
  localparam int FRAC_BITS = 4;
  localparam int DIVD_W    = SUM_W + FRAC_BITS;
  localparam int STEP_W    = $clog2(DIVD_W);

  typedef enum logic [0:0] {
    ACT_ACCUM = 1'b0,
    ACT_READ  = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SEL_HS,
    SEL_HL,
    SEL_LX
  } mean_sel_t;

  typedef struct packed {
    logic [SUM_W-1:0] hits;
    logic [SUM_W-1:0] sum_lx;
    logic [SUM_W-1:0] sum_hl;
    logic [SUM_W-1:0] sum_hs;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/pccm_if.sv
// pccm_if: valid/ready channel interfaces for input items and results
// depends on pccm_pkg
`timescale 1ns / 1ps

interface pccm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [pccm_pkg::CHAN_W-1:0] channel;
  logic [pccm_pkg::CHG_W-1:0]  charge_hs;
  logic [pccm_pkg::CHG_W-1:0]  charge_hl;
  logic [pccm_pkg::CHG_W-1:0]  charge_lx;

  modport source (output valid, action, channel, charge_hs, charge_hl, charge_lx,
                  input ready);
  modport sink (input valid, action, channel, charge_hs, charge_hl, charge_lx,
                output ready);
endinterface

interface pccm_out_if;
  logic                        valid;
  logic                        ready;
  logic [pccm_pkg::CHAN_W-1:0] out_channel;
  logic [pccm_pkg::MEAN_W-1:0] mean_hs;
  logic [pccm_pkg::MEAN_W-1:0] mean_hl;
  logic [pccm_pkg::MEAN_W-1:0] mean_lx;
  logic [pccm_pkg::SUM_W-1:0]  hit_count;

  modport source (output valid, out_channel, mean_hs, mean_hl, mean_lx, hit_count,
                  input ready);
  modport sink (input valid, out_channel, mean_hs, mean_hl, mean_lx, hit_count,
                output ready);
endinterface

>>> rtl/pccm_store.sv
// pccm_store: per-channel sums and hit counts, one write and one registered read port
// depends on pccm_pkg
`timescale 1ns / 1ps

module pccm_store (
  input  logic               clk,
  input  pccm_pkg::ram_req_t req,
  output pccm_pkg::entry_t   rdata
);

  pccm_pkg::entry_t mem [pccm_pkg::CHANNELS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

>>> rtl/pccm_div.sv
// pccm_div: shared restoring divider, one quotient bit per cycle, saturating result
// depends on pccm_pkg
`timescale 1ns / 1ps

module pccm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pccm_pkg::DIVD_W-1:0] dividend,
  input  logic [pccm_pkg::SUM_W-1:0]  divisor,
  output pccm_pkg::div_stat_t         stat,
  output logic [pccm_pkg::MEAN_W-1:0] quot
);

  logic [pccm_pkg::SUM_W-1:0]  rem;
  logic [pccm_pkg::SUM_W-1:0]  dsor;
  logic [pccm_pkg::DIVD_W-1:0] qsh;
  logic [pccm_pkg::STEP_W-1:0] cnt;
  logic                        busy;
  logic                        done;

  logic [pccm_pkg::SUM_W:0]   trial;
  logic [pccm_pkg::SUM_W+1:0] diff;

  assign trial = {rem, qsh[pccm_pkg::DIVD_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= pccm_pkg::STEP_W'(pccm_pkg::DIVD_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dsor <= divisor;
      qsh  <= dividend;
    end else if (busy) begin
      if (!diff[pccm_pkg::SUM_W+1]) begin
        rem <= diff[pccm_pkg::SUM_W-1:0];
        qsh <= {qsh[pccm_pkg::DIVD_W-2:0], 1'b1};
      end else begin
        rem <= trial[pccm_pkg::SUM_W-1:0];
        qsh <= {qsh[pccm_pkg::DIVD_W-2:0], 1'b0};
      end
    end
  end

  assign quot = (|qsh[pccm_pkg::DIVD_W-1:pccm_pkg::MEAN_W]) ? '1
              : qsh[pccm_pkg::MEAN_W-1:0];

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

>>> rtl/per_channel_charge_mean.sv
// per_channel_charge_mean: top level, sequencer around the channel store and shared divider
// depends on pccm_pkg, pccm_if, pccm_store, pccm_div
`timescale 1ns / 1ps

// Keeps three saturating charge sums and a hit count per channel in one memory row.
// After reset a clearing pass writes zero to all 9728 rows, one per cycle, and no item is
// taken until it ends. An accumulate item does a memory read, then a saturating add and
// write back. A read item fetches and clears its row, then one shared 36-step restoring
// divider produces the three means in turn. An out-of-range read skips the store and
// yields zero means and a zero count; an out-of-range accumulate is dropped.
// The result sits in an output register, so the next item is taken while it waits.
module per_channel_charge_mean (
  input  logic              clk,
  input  logic              rst,
  pccm_in_if.sink           items,
  pccm_out_if.source        results
);

  pccm_pkg::state_t    state;
  pccm_pkg::state_t    state_next;
  pccm_pkg::mean_sel_t mean_sel;

  logic [pccm_pkg::ADDR_W-1:0] clr_addr;
  logic                        act;
  logic [pccm_pkg::CHAN_W-1:0] chan;
  logic [pccm_pkg::CHG_W-1:0]  chs;
  logic [pccm_pkg::CHG_W-1:0]  chl;
  logic [pccm_pkg::CHG_W-1:0]  clx;
  pccm_pkg::entry_t            ent;
  logic [pccm_pkg::MEAN_W-1:0] m_hs;
  logic [pccm_pkg::MEAN_W-1:0] m_hl;
  logic [pccm_pkg::MEAN_W-1:0] m_lx;
  logic                        res_valid;

  pccm_pkg::ram_req_t  ram_req;
  pccm_pkg::entry_t    ram_rdata;
  pccm_pkg::entry_t    acc_row;
  pccm_pkg::div_stat_t div_stat;
  logic                        div_start;
  logic [pccm_pkg::SUM_W-1:0]  div_sum;
  logic [pccm_pkg::SUM_W-1:0]  div_cnt;
  logic [pccm_pkg::MEAN_W-1:0] div_quot;
  logic                        in_xfer;
  logic                        in_range;
  logic                        out_free;

  function automatic logic [pccm_pkg::SUM_W-1:0] sat_add(
    input logic [pccm_pkg::SUM_W-1:0] a,
    input logic [pccm_pkg::SUM_W-1:0] b
  );
    logic [pccm_pkg::SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[pccm_pkg::SUM_W] ? '1 : s[pccm_pkg::SUM_W-1:0];
  endfunction

  pccm_store u_store (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  pccm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({div_sum, pccm_pkg::FRAC_BITS'(0)}),
    .divisor  (div_cnt),
    .stat     (div_stat),
    .quot     (div_quot)
  );

  assign items.ready = (state == pccm_pkg::ST_IDLE);
  assign in_xfer     = items.valid && items.ready;
  assign in_range    = items.channel < pccm_pkg::CHAN_W'(pccm_pkg::CHANNELS);
  assign out_free    = !res_valid || results.ready;

  assign acc_row.sum_hs = sat_add(ram_rdata.sum_hs, pccm_pkg::SUM_W'(chs));
  assign acc_row.sum_hl = sat_add(ram_rdata.sum_hl, pccm_pkg::SUM_W'(chl));
  assign acc_row.sum_lx = sat_add(ram_rdata.sum_lx, pccm_pkg::SUM_W'(clx));
  assign acc_row.hits   = sat_add(ram_rdata.hits, pccm_pkg::SUM_W'(1));

  assign div_cnt = (ent.hits == '0) ? pccm_pkg::SUM_W'(1) : ent.hits;

  always_comb begin
    case (mean_sel)
      pccm_pkg::SEL_HS: div_sum = ent.sum_hs;
      pccm_pkg::SEL_HL: div_sum = ent.sum_hl;
      pccm_pkg::SEL_LX: div_sum = ent.sum_lx;
      default:          div_sum = ent.sum_hs;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pccm_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    ram_req.we    = 1'b0;
    ram_req.waddr = chan[pccm_pkg::ADDR_W-1:0];
    ram_req.wdata = '0;
    ram_req.re    = 1'b0;
    ram_req.raddr = items.channel[pccm_pkg::ADDR_W-1:0];
    div_start     = 1'b0;
    case (state)
      pccm_pkg::ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_addr;
        if (clr_addr == pccm_pkg::ADDR_W'(pccm_pkg::CHANNELS - 1)) begin
          state_next = pccm_pkg::ST_IDLE;
        end
      end
      pccm_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_range) begin
            ram_req.re = 1'b1;
            state_next = pccm_pkg::ST_FETCH;
          end else if (items.action == pccm_pkg::ACT_READ) begin
            state_next = pccm_pkg::ST_EMIT;
          end
        end
      end
      pccm_pkg::ST_FETCH: begin
        ram_req.we = 1'b1;
        if (act == pccm_pkg::ACT_ACCUM) begin
          ram_req.wdata = acc_row;
          state_next    = pccm_pkg::ST_IDLE;
        end else begin
          state_next = pccm_pkg::ST_DIV_GO;
        end
      end
      pccm_pkg::ST_DIV_GO: begin
        div_start  = 1'b1;
        state_next = pccm_pkg::ST_DIV_WAIT;
      end
      pccm_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_next = (mean_sel == pccm_pkg::SEL_LX) ? pccm_pkg::ST_EMIT
                                                      : pccm_pkg::ST_DIV_GO;
        end
      end
      pccm_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = pccm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pccm_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      mean_sel  <= pccm_pkg::SEL_HS;
      res_valid <= 1'b0;
    end else begin
      if (state == pccm_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == pccm_pkg::ST_FETCH) begin
        mean_sel <= pccm_pkg::SEL_HS;
      end else if (state == pccm_pkg::ST_DIV_WAIT && div_stat.done) begin
        case (mean_sel)
          pccm_pkg::SEL_HS: mean_sel <= pccm_pkg::SEL_HL;
          pccm_pkg::SEL_HL: mean_sel <= pccm_pkg::SEL_LX;
          default:          mean_sel <= pccm_pkg::SEL_HS;
        endcase
      end
      if (state == pccm_pkg::ST_EMIT && out_free) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act  <= items.action;
      chan <= items.channel;
      chs  <= items.charge_hs;
      chl  <= items.charge_hl;
      clx  <= items.charge_lx;
      if (!in_range) begin
        ent.hits <= '0;
        m_hs     <= '0;
        m_hl     <= '0;
        m_lx     <= '0;
      end
    end
    if (state == pccm_pkg::ST_FETCH) begin
      ent <= ram_rdata;
    end
    if (state == pccm_pkg::ST_DIV_WAIT && div_stat.done) begin
      case (mean_sel)
        pccm_pkg::SEL_HS: m_hs <= div_quot;
        pccm_pkg::SEL_HL: m_hl <= div_quot;
        pccm_pkg::SEL_LX: m_lx <= div_quot;
        default:          m_hs <= div_quot;
      endcase
    end
    if (state == pccm_pkg::ST_EMIT && out_free) begin
      results.out_channel <= chan;
      results.mean_hs     <= m_hs;
      results.mean_hl     <= m_hl;
      results.mean_lx     <= m_lx;
      results.hit_count   <= ent.hits;
    end
  end

  assign results.valid = res_valid;

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == pccm_pkg::ST_EMIT))
    else $error("result loaded outside the emit step");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> (ram_req.waddr < pccm_pkg::ADDR_W'(pccm_pkg::CHANNELS)))
    else $error("store write beyond the last channel");

  a_no_take_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == pccm_pkg::ST_CLEAR) |-> !ram_req.re && !items.ready)
    else $error("item taken during clearing pass");

endmodule

>>> tb/tb_per_channel_charge_mean.sv
// tb_per_channel_charge_mean: self-checking bench for the per-channel charge mean block
// depends on pccm_pkg, pccm_if and per_channel_charge_mean
// directed table first, then random hits and reads checked against a channel store predictor
`timescale 1ns / 1ps

module tb_per_channel_charge_mean;
  import pccm_pkg::*;

  localparam int RAND_ITEMS   = 800;
  localparam int HOLD_CYCLES  = 1500;
  localparam int DRAIN_CYCLES = 200;
  localparam int IDLE_LIMIT   = 30000;
  localparam logic [CHG_W-1:0] CHG_MAX = '1;

  typedef struct packed {
    action_t           action;
    logic [CHAN_W-1:0] channel;
    logic [CHG_W-1:0]  charge_hs;
    logic [CHG_W-1:0]  charge_hl;
    logic [CHG_W-1:0]  charge_lx;
  } hit_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_channel;
    logic [MEAN_W-1:0] mean_hs;
    logic [MEAN_W-1:0] mean_hl;
    logic [MEAN_W-1:0] mean_lx;
    logic [SUM_W-1:0]  hit_count;
  } means_t;

  typedef struct packed {
    hit_t   hit;
    logic   typed;
    means_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pccm_in_if  hit_ch ();
  pccm_out_if mean_ch ();

  per_channel_charge_mean dut (
    .clk     (clk),
    .rst     (rst),
    .items   (hit_ch.sink),
    .results (mean_ch.source)
  );

  always #5 clk = ~clk;

  logic [SUM_W-1:0] acc_hs   [CHANNELS];
  logic [SUM_W-1:0] acc_hl   [CHANNELS];
  logic [SUM_W-1:0] acc_lx   [CHANNELS];
  logic [SUM_W-1:0] acc_hits [CHANNELS];

  means_t   pending_means[$];
  dir_row_t dir_rows[$];
  int       bad_results = 0;
  int       idle_cycles = 0;
  bit       steady = 1'b0;
  bit       hold_req = 1'b0;
  means_t   seen_m;
  means_t   want_m;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [CHG_W-1:0] rand_charge();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CHG_MAX;
      default: return CHG_W'($urandom_range(0, 2**CHG_W - 1));
    endcase
  endfunction

  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

  function automatic logic [MEAN_W-1:0] frac_mean(logic [SUM_W-1:0] sum,
                                                   logic [SUM_W-1:0] count);
    logic [63:0] d;
    logic [63:0] q;
    d = (count == '0) ? 64'd1 : {32'd0, count};
    q = {28'd0, sum, 4'd0} / d;
    return (q > 64'hFFFF) ? '1 : q[MEAN_W-1:0];
  endfunction

  // updates the channel store, returns 1 when the transfer yields a result
  function automatic bit fold_hit(input hit_t h, output means_t res);
    int unsigned ch;
    ch = 32'(h.channel);
    res = '0;
    res.out_channel = h.channel;
    if (h.action == ACT_ACCUM) begin
      if (ch < CHANNELS) begin
        acc_hs[ch]   = sat_sum(acc_hs[ch], SUM_W'(h.charge_hs));
        acc_hl[ch]   = sat_sum(acc_hl[ch], SUM_W'(h.charge_hl));
        acc_lx[ch]   = sat_sum(acc_lx[ch], SUM_W'(h.charge_lx));
        acc_hits[ch] = sat_sum(acc_hits[ch], SUM_W'(1));
      end
      return 1'b0;
    end
    if (ch < CHANNELS) begin
      res.mean_hs   = frac_mean(acc_hs[ch], acc_hits[ch]);
      res.mean_hl   = frac_mean(acc_hl[ch], acc_hits[ch]);
      res.mean_lx   = frac_mean(acc_lx[ch], acc_hits[ch]);
      res.hit_count = acc_hits[ch];
      acc_hs[ch]   = '0;
      acc_hl[ch]   = '0;
      acc_lx[ch]   = '0;
      acc_hits[ch] = '0;
    end
    return 1'b1;
  endfunction

  // enters at a falling edge, returns at a falling edge
  task automatic send_hit(input hit_t h, input bit typed, input means_t want);
    means_t got;
    int gap;
    hit_ch.valid     = 1'b1;
    hit_ch.action    = h.action;
    hit_ch.channel   = h.channel;
    hit_ch.charge_hs = h.charge_hs;
    hit_ch.charge_hl = h.charge_hl;
    hit_ch.charge_lx = h.charge_lx;
    do @(posedge clk); while (!hit_ch.ready);
    if (fold_hit(h, got)) pending_means.push_back(typed ? want : got);
    @(negedge clk);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      hit_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    mean_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        mean_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0 && !steady) begin
        mean_ch.ready = 1'b0;
        stall_left--;
      end else begin
        mean_ch.ready = 1'b1;
        stall_left = steady ? 0 : pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (mean_ch.valid && mean_ch.ready) begin
      seen_m = '{mean_ch.out_channel, mean_ch.mean_hs, mean_ch.mean_hl,
                 mean_ch.mean_lx, mean_ch.hit_count};
      if (pending_means.size() == 0) begin
        if (bad_results < 10)
          $display("unexpected result: ch %0d hs %0d hl %0d lx %0d count %0d",
                   seen_m.out_channel, seen_m.mean_hs, seen_m.mean_hl,
                   seen_m.mean_lx, seen_m.hit_count);
        bad_results++;
      end else begin
        want_m = pending_means.pop_front();
        if (seen_m.out_channel != want_m.out_channel || seen_m.mean_hs != want_m.mean_hs ||
            seen_m.mean_hl != want_m.mean_hl || seen_m.mean_lx != want_m.mean_lx ||
            seen_m.hit_count != want_m.hit_count) begin
          if (bad_results < 10) begin
            $write("mismatch: exp ch %0d hs %0d hl %0d lx %0d count %0d, ",
                   want_m.out_channel, want_m.mean_hs, want_m.mean_hl,
                   want_m.mean_lx, want_m.hit_count);
            $display("got ch %0d hs %0d hl %0d lx %0d count %0d",
                     seen_m.out_channel, seen_m.mean_hs, seen_m.mean_hl,
                     seen_m.mean_lx, seen_m.hit_count);
          end
          bad_results++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((hit_ch.valid && hit_ch.ready) || (mean_ch.valid && mean_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("[per_channel_charge_mean] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned hot[8];
    int r;
    hit_t h;
    hit_ch.valid     = 1'b0;
    hit_ch.action    = ACT_ACCUM;
    hit_ch.channel   = '0;
    hit_ch.charge_hs = '0;
    hit_ch.charge_hl = '0;
    hit_ch.charge_lx = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      acc_hs[i]   = '0;
      acc_hl[i]   = '0;
      acc_lx[i]   = '0;
      acc_hits[i] = '0;
    end

    // empty, out-of-range and extreme channels, full-scale and zero charges
    dir_rows.push_back('{'{ACT_READ, 14'd0, 12'h0, 12'h0, 12'h0}, 1'b1,
                         '{14'd0, 16'd0, 16'd0, 16'd0, 32'd0}});
    dir_rows.push_back('{'{ACT_READ, 14'd9727, 12'h0, 12'h0, 12'h0}, 1'b1,
                         '{14'd9727, 16'd0, 16'd0, 16'd0, 32'd0}});
    dir_rows.push_back('{'{ACT_READ, 14'd9728, 12'h0, 12'h0, 12'h0}, 1'b1,
                         '{14'd9728, 16'd0, 16'd0, 16'd0, 32'd0}});
    dir_rows.push_back('{'{ACT_READ, 14'd16383, 12'h0, 12'h0, 12'h0}, 1'b1,
                         '{14'd16383, 16'd0, 16'd0, 16'd0, 32'd0}});
    dir_rows.push_back('{'{ACT_ACCUM, 14'd9728, 12'hFFF, 12'hFFF, 12'hFFF}, 1'b0, '0});
    dir_rows.push_back('{'{ACT_ACCUM, 14'd16383, 12'hAAA, 12'h555, 12'hFFF}, 1'b0, '0});
    dir_rows.push_back('{'{ACT_READ, 14'd9728, 12'h0, 12'h0, 12'h0}, 1'b1,
                         '{14'd9728, 16'd0, 16'd0, 16'd0, 32'd0}});
    dir_rows.push_back('{'{ACT_READ, 14'd16383, 12'h0, 12'h0, 12'h0}, 1'b1,
                         '{14'd16383, 16'd0, 16'd0, 16'd0, 32'd0}});
    dir_rows.push_back('{'{ACT_ACCUM, 14'd0, 12'hFFF, 12'hFFF, 12'hFFF}, 1'b0, '0});
    dir_rows.push_back('{'{ACT_READ, 14'd0, 12'h0, 12'h0, 12'h0}, 1'b1,
                         '{14'd0, 16'd65520, 16'd65520, 16'd65520, 32'd1}});
    dir_rows.push_back('{'{ACT_READ, 14'd0, 12'h0, 12'h0, 12'h0}, 1'b1,
                         '{14'd0, 16'd0, 16'd0, 16'd0, 32'd0}});
    dir_rows.push_back('{'{ACT_ACCUM, 14'd9727, 12'h0, 12'h0, 12'h0}, 1'b0, '0});
    dir_rows.push_back('{'{ACT_READ, 14'd9727, 12'h0, 12'h0, 12'h0}, 1'b1,
                         '{14'd9727, 16'd0, 16'd0, 16'd0, 32'd1}});
    dir_rows.push_back('{'{ACT_ACCUM, 14'd5, 12'hFFF, 12'h000, 12'hAAA}, 1'b0, '0});
    dir_rows.push_back('{'{ACT_ACCUM, 14'd5, 12'h000, 12'hFFF, 12'h555}, 1'b0, '0});
    dir_rows.push_back('{'{ACT_ACCUM, 14'd5, 12'h001, 12'h002, 12'h003}, 1'b0, '0});
    dir_rows.push_back('{'{ACT_READ, 14'd5, 12'h0, 12'h0, 12'h0}, 1'b0, '0});
    dir_rows.push_back('{'{ACT_ACCUM, 14'd5461, 12'h555, 12'hAAA, 12'h800}, 1'b0, '0});
    dir_rows.push_back('{'{ACT_ACCUM, 14'd5461, 12'hAAA, 12'h555, 12'h7FF}, 1'b0, '0});
    dir_rows.push_back('{'{ACT_READ, 14'd5461, 12'h0, 12'h0, 12'h0}, 1'b0, '0});
    dir_rows.push_back('{'{ACT_ACCUM, 14'd8191, 12'h123, 12'h456, 12'h789}, 1'b0, '0});
    dir_rows.push_back('{'{ACT_ACCUM, 14'd8191, 12'hFFF, 12'hFFF, 12'h000}, 1'b0, '0});
    dir_rows.push_back('{'{ACT_READ, 14'd8191, 12'h0, 12'h0, 12'h0}, 1'b0, '0});

    hot = '{0, 1, 31, 511, 512, 9727, $urandom_range(0, 9727), $urandom_range(0, 9727)};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i])
      send_hit(dir_rows[i].hit, dir_rows[i].typed, dir_rows[i].want);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 300) begin
        // long result hold while hits and reads keep coming
        hold_req = 1'b1;
        steady = 1'b1;
        for (int k = 0; k < 12; k++) begin
          h = '{action_t'((k % 2 == 0) ? ACT_READ : ACT_ACCUM), CHAN_W'(hot[k % 8]),
                rand_charge(), rand_charge(), rand_charge()};
          send_hit(h, 1'b0, '0);
        end
        steady = 1'b0;
      end
      if (n == 500) begin
        hit_ch.valid = 1'b0;
        while (pending_means.size() != 0) @(negedge clk);
      end
      steady = (n >= 600 && n < 700);
      r = $urandom_range(0, 99);
      if (r < 70)
        h = '{ACT_ACCUM, CHAN_W'(hot[$urandom_range(0, 7)]),
              rand_charge(), rand_charge(), rand_charge()};
      else if (r < 85)
        h = '{ACT_READ, CHAN_W'(hot[$urandom_range(0, 7)]),
              rand_charge(), rand_charge(), rand_charge()};
      else if (r < 92)
        h = '{ACT_ACCUM, CHAN_W'($urandom_range(0, 2**CHAN_W - 1)),
              rand_charge(), rand_charge(), rand_charge()};
      else
        h = '{ACT_READ, CHAN_W'($urandom_range(0, 2**CHAN_W - 1)),
              rand_charge(), rand_charge(), rand_charge()};
      send_hit(h, 1'b0, '0);
    end
    steady = 1'b0;
    hit_ch.valid = 1'b0;

    while (pending_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_results == 0)
      $display("[per_channel_charge_mean] OK");
    else
      $display("[per_channel_charge_mean] ERROR");
    $finish;
  end

endmodule
